FILE: hw/rtl/mse_pkg.sv
// Shared types and helpers for the merge sort engine.
`default_nettype none
package mse_pkg;
    localparam int VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] t_word;

    // Ascending order with ties kept in arrival order: left run wins on equal keys.
    function automatic logic key_le(input t_word a, input t_word b);
        key_le = (a <= b);
    endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/merge_sort_engine.sv
// Merge sort engine top level: load, bottom-up merge passes, sorted readout.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------
//  input   | in        | i_valid / o_stall  | i_value, i_last_in
//  output  | out       | o_valid / i_stall  | o_sorted_value, o_last_out, o_overflow
//
// Loading accepts one request per cycle; the request flagged last starts the sort.
// Sorting runs ceil(log2 n) passes over n held values; per pass each value goes through
// S_RD and S_CMP via the single comparator and the two-port read of the ping-pong RAMs,
// plus an S_SEG setup per merged segment, an S_PASS per pass and one more to end the sort.
// Readout reads (S_ORD), registers (S_OLD) and holds (S_OUT) each result until taken.
// o_stall stays high from the last request until the final result is taken. Reset
// (synchronous, active low) empties the set; RAMs keep no reset.
`default_nettype none
module merge_sort_engine #(
    parameter int DEPTH = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire mse_pkg::t_word i_value,
    input  wire logic          i_last_in,
    output logic               o_valid,
    input  wire logic          i_stall,
    output mse_pkg::t_word     o_sorted_value,
    output logic               o_last_out,
    output logic               o_overflow
);
    import mse_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = CW + 1;
    localparam int SW = CW + 2;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_PASS = 3'd1;
    localparam logic [2:0] S_SEG  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_ORD  = 3'd5;
    localparam logic [2:0] S_OLD  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]    r_state;
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [CW-1:0] r_n;
    logic [WW-1:0] r_w;
    logic          r_src;
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_lo;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic [CW-1:0] r_mid;
    logic [CW-1:0] r_hi;
    t_word         r_out_value;
    logic          r_out_last;

    logic          in_acc;
    logic          out_acc;
    logic          room;
    logic [CW-1:0] kp1;
    logic [SW-1:0] sum_mid;
    logic [SW-1:0] sum_hi;
    logic [CW-1:0] seg_mid;
    logic [CW-1:0] seg_hi;
    logic          take_left;
    t_word         rd_a;
    t_word         rd_b;
    t_word         pick;

    logic          a_we;
    logic          b_we;
    logic [AW-1:0] a_waddr;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    t_word         a_wdata;
    logic [VALUE_W-1:0] a_rdata_a;
    logic [VALUE_W-1:0] a_rdata_b;
    logic [VALUE_W-1:0] b_rdata_a;
    logic [VALUE_W-1:0] b_rdata_b;

    assign o_stall        = (r_state != S_LOAD);
    assign o_valid        = (r_state == S_OUT);
    assign o_sorted_value = r_out_value;
    assign o_last_out     = r_out_last;
    assign o_overflow     = r_ovf;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign room    = (r_count < CW'(DEPTH));
    assign kp1     = r_k + CW'(1);

    // Segment bounds, clamped to the set size.
    assign sum_mid = {2'b00, r_lo} + {1'b0, r_w};
    assign sum_hi  = {2'b00, r_lo} + {r_w, 1'b0};
    assign seg_mid = (sum_mid > {2'b00, r_n}) ? r_n : sum_mid[CW-1:0];
    assign seg_hi  = (sum_hi > {2'b00, r_n}) ? r_n : sum_hi[CW-1:0];

    assign rd_a      = r_src ? t_word'(b_rdata_a) : t_word'(a_rdata_a);
    assign rd_b      = r_src ? t_word'(b_rdata_b) : t_word'(a_rdata_b);
    assign take_left = (r_i < r_mid) && ((r_j >= r_hi) || key_le(rd_a, rd_b));
    assign pick      = take_left ? rd_a : rd_b;

    // Buffer A takes the loaded set; during a merge the destination is the non-source RAM.
    always_comb begin
        a_we    = 1'b0;
        b_we    = 1'b0;
        a_waddr = r_k[AW-1:0];
        a_wdata = pick;
        if (r_state == S_LOAD) begin
            a_we    = in_acc && room;
            a_waddr = r_count[AW-1:0];
            a_wdata = i_value;
        end else if (r_state == S_CMP) begin
            a_we = r_src;
            b_we = !r_src;
        end
    end

    assign raddr_a = (r_state == S_ORD) ? r_k[AW-1:0] : r_i[AW-1:0];
    assign raddr_b = r_j[AW-1:0];

    mse_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_buf_a (
        .i_clk     (i_clk),
        .i_we      (a_we),
        .i_waddr   (a_waddr),
        .i_wdata   (a_wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (a_rdata_a),
        .o_rdata_b (a_rdata_b)
    );

    mse_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_buf_b (
        .i_clk     (i_clk),
        .i_we      (b_we),
        .i_waddr   (r_k[AW-1:0]),
        .i_wdata   (pick),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (b_rdata_a),
        .o_rdata_b (b_rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_w     <= WW'(1);
            r_src   <= 1'b0;
            r_k     <= '0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (room) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_in) begin
                            r_state <= S_PASS;
                        end
                    end
                end
                S_PASS: begin
                    r_k <= '0;
                    if (r_w >= {1'b0, r_n}) begin
                        r_state <= S_ORD;
                    end else begin
                        r_state <= S_SEG;
                    end
                end
                S_SEG: begin
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_k <= kp1;
                    if (kp1 == r_n) begin
                        // Pass done: swap source and destination, double the run length.
                        r_w     <= {r_w[WW-2:0], 1'b0};
                        r_src   <= !r_src;
                        r_state <= S_PASS;
                    end else if (kp1 == r_hi) begin
                        r_state <= S_SEG;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_ORD: begin
                    r_state <= S_OLD;
                end
                S_OLD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_acc) begin
                        r_k <= kp1;
                        if (r_out_last) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_w     <= WW'(1);
                            r_src   <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_state <= S_ORD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // Datapath registers, no reset.
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && in_acc && i_last_in) begin
            r_n <= room ? r_count + CW'(1) : r_count;
        end
        if (r_state == S_PASS) begin
            r_lo <= '0;
        end
        if (r_state == S_SEG) begin
            r_i   <= r_lo;
            r_mid <= seg_mid;
            r_j   <= seg_mid;
            r_hi  <= seg_hi;
        end
        if (r_state == S_CMP) begin
            if (take_left) begin
                r_i <= r_i + CW'(1);
            end else begin
                r_j <= r_j + CW'(1);
            end
            if (kp1 == r_hi) begin
                r_lo <= r_hi;
            end
        end
        if (r_state == S_OLD) begin
            r_out_value <= rd_a;
            r_out_last  <= (kp1 == r_n);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count beyond buffer depth");

    a_merge_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_k < r_n) && (r_k < r_hi))
        else $error("merge write past end of segment");

    a_merge_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_i < r_mid) || (r_j < r_hi))
        else $error("merge step with both runs exhausted");

    a_busy_when_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("accepting input while emitting results");

    a_back_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last_out) |=> !o_stall && (r_count == '0) && !r_ovf)
        else $error("set not cleared after final result");
endmodule
`default_nettype wire

FILE: hw/rtl/mse_ram.sv
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule
`default_nettype wire
